/* hw/rtl/psdw_pkg.sv */
// -----------------------------------------------------------------------------
// psdw_pkg
// Shared types, constants and byte helpers of the PNG stored-deflate writer.
// -----------------------------------------------------------------------------
package psdw_pkg;

  localparam int unsigned MaxSide  = 16384;
  localparam int unsigned BlkMax   = 65535;   // stored block limit
  localparam int unsigned AdlerMod = 65521;

  localparam logic [31:0] CrcPoly  = 32'hEDB88320;
  localparam logic [31:0] TagIhdr  = 32'h49484452;
  localparam logic [31:0] TagIdat  = 32'h49444154;
  localparam logic [31:0] TagIend  = 32'h49454E44;

  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_file;
  } out_beat_t;

  // checksum controls from the sequencer
  typedef struct packed {
    logic       crc_feed;
    logic       crc_restart;
    logic       adler_feed;
    logic       adler_init;
    logic [7:0] data;
  } ck_ctrl_t;

  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? (CrcPoly ^ (r >> 1)) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [7:0] be_byte(logic [31:0] v, logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd0:    r = v[31:24];
      2'd1:    r = v[23:16];
      2'd2:    r = v[15:8];
      default: r = v[7:0];
    endcase
    return r;
  endfunction

  function automatic logic [7:0] sig_byte(logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0:    r = 8'h89;
      3'd1:    r = 8'h50;
      3'd2:    r = 8'h4E;
      3'd3:    r = 8'h47;
      3'd4:    r = 8'h0D;
      3'd5:    r = 8'h0A;
      3'd6:    r = 8'h1A;
      default: r = 8'h0A;
    endcase
    return r;
  endfunction

  function automatic logic [14:0] clamp_side(logic [14:0] v);
    logic [14:0] r;
    r = v;
    if (v == 15'd0) begin
      r = 15'd1;
    end else if (v > 15'(MaxSide)) begin
      r = 15'(MaxSide);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/psdw_if.sv */
// -----------------------------------------------------------------------------
// psdw_if
// Valid/ready channels for pixel input beats and PNG byte beats.
// -----------------------------------------------------------------------------
interface psdw_in_if;
  logic               valid;
  logic               ready;
  psdw_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface psdw_out_if;
  logic                valid;
  logic                ready;
  psdw_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/psdw_checksum.sv */
// -----------------------------------------------------------------------------
// psdw_checksum
// Running chunk CRC-32 and zlib Adler-32, one byte per cycle.
// -----------------------------------------------------------------------------
module psdw_checksum (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psdw_pkg::ck_ctrl_t  ctrl_i,
  output logic [31:0]         crc_o,
  output logic [31:0]         adler_o
);

  logic [31:0] crc_q, crc_d, crc_base;
  logic [15:0] lo_q, lo_d, hi_q, hi_d;
  logic [16:0] lo_s, lo_n, hi_s;

  assign crc_base = ctrl_i.crc_restart ? 32'hFFFFFFFF : crc_q;
  assign crc_d    = psdw_pkg::crc_byte(crc_base, ctrl_i.data);

  always_comb begin
    lo_s = {1'b0, lo_q} + {9'd0, ctrl_i.data};
    lo_n = (lo_s >= 17'(psdw_pkg::AdlerMod)) ? lo_s - 17'(psdw_pkg::AdlerMod) : lo_s;
    hi_s = {1'b0, hi_q} + lo_n;
    lo_d = lo_n[15:0];
    hi_d = (hi_s >= 17'(psdw_pkg::AdlerMod)) ? 16'(hi_s - 17'(psdw_pkg::AdlerMod))
                                             : hi_s[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= 32'hFFFFFFFF;
      lo_q  <= 16'd1;
      hi_q  <= 16'd0;
    end else begin
      if (ctrl_i.crc_feed) begin
        crc_q <= crc_d;
      end
      if (ctrl_i.adler_init) begin
        lo_q <= 16'd1;
        hi_q <= 16'd0;
      end else if (ctrl_i.adler_feed) begin
        lo_q <= lo_d;
        hi_q <= hi_d;
      end
    end
  end

  assign crc_o   = crc_q;
  assign adler_o = {hi_q, lo_q};

endmodule

/* hw/rtl/psdw_seq.sv */
// -----------------------------------------------------------------------------
// psdw_seq
// Byte sequencer: walks the PNG layout for one item and drives the byte register.
// -----------------------------------------------------------------------------
module psdw_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  psdw_in_if.sink            in_if,
  psdw_out_if.source         out_if,
  input  logic [14:0]        width_i,
  input  logic [14:0]        height_i,
  input  logic [31:0]        crc_i,
  input  logic [31:0]        adler_i,
  output psdw_pkg::ck_ctrl_t ctrl_o,
  output logic               streaming_o
);

  typedef enum logic [3:0] {
    SEG_SIG, SEG_LEN, SEG_TAG, SEG_IHDR, SEG_ZHDR,
    SEG_BLK, SEG_DATA, SEG_ADLER, SEG_CRC
  } seg_e;
  typedef enum logic [1:0] {CH_IHDR, CH_IDAT, CH_IEND} chunk_e;
  typedef enum logic [1:0] {PH_IDLE, PH_STREAM, PH_DONE} phase_e;

  logic               busy_q;
  seg_e               seg_q, seg_n;
  chunk_e             chunk_q, chunk_n;
  phase_e             phase_q;
  logic [3:0]         idx_q, idx_n;
  logic [2:0]         slot_q, slot_n;
  logic               last_q;
  psdw_pkg::in_beat_t pix_q;
  logic [13:0]        col_q, row_q;
  logic [15:0]        block_left_q;
  logic [31:0]        raw_left_q, sum_q, idat_len_q;
  logic [15:0]        nblk_q;
  psdw_pkg::out_beat_t out_q;
  logic               out_vld_q;

  logic        out_adv, emit, in_acc, fin, eof, data_step, load_blk, need_hdr;
  logic        start_take, pix_take, in_take;
  logic [7:0]  byte_v, hdr_b, samp_b;
  logic [15:0] blk;
  logic [2:0]  hdr_i;
  logic [31:0] len_val, tag_val, raw_init;
  logic [14:0] col_nx, row_nx;
  psdw_pkg::ck_ctrl_t ctrl;

  assign out_adv = !out_vld_q || out_if.ready;
  assign emit    = busy_q && out_adv;
  assign in_if.ready = !busy_q || (emit && fin);
  assign in_acc  = in_if.valid && in_if.ready;

  // start always taken; a pixel only while an image is open
  assign start_take = in_acc && (in_if.data.kind == psdw_pkg::KIND_START);
  assign pix_take   = in_acc && (in_if.data.kind == psdw_pkg::KIND_PIXEL) &&
                      (phase_q == PH_STREAM);
  assign in_take    = start_take || pix_take;

  assign need_hdr = (block_left_q == 16'd0) && (raw_left_q != 32'd0);
  assign blk      = (raw_left_q < 32'(psdw_pkg::BlkMax)) ? raw_left_q[15:0]
                                                         : 16'(psdw_pkg::BlkMax);
  assign hdr_i    = (seg_q == SEG_BLK) ? idx_q[2:0] : 3'd0;
  assign raw_init = {17'd0, height_i} * {15'd0, {width_i, 2'b00} + 17'd1};
  assign col_nx   = {1'b0, col_q} + 15'd1;
  assign row_nx   = {1'b0, row_q} + 15'd1;

  always_comb begin
    case (hdr_i)
      3'd0:    hdr_b = (raw_left_q <= 32'(psdw_pkg::BlkMax)) ? 8'd1 : 8'd0;
      3'd1:    hdr_b = blk[7:0];
      3'd2:    hdr_b = blk[15:8];
      3'd3:    hdr_b = ~blk[7:0];
      default: hdr_b = ~blk[15:8];
    endcase
    case (slot_q)
      3'd0:    samp_b = 8'd0;       // row filter type none
      3'd1:    samp_b = pix_q.red;
      3'd2:    samp_b = pix_q.green;
      3'd3:    samp_b = pix_q.blue;
      default: samp_b = pix_q.alpha;
    endcase
    case (chunk_q)
      CH_IHDR: begin len_val = 32'd13;     tag_val = psdw_pkg::TagIhdr; end
      CH_IDAT: begin len_val = idat_len_q; tag_val = psdw_pkg::TagIdat; end
      default: begin len_val = 32'd0;      tag_val = psdw_pkg::TagIend; end
    endcase
  end

  always_comb begin
    byte_v    = 8'd0;
    eof       = 1'b0;
    fin       = 1'b0;
    seg_n     = seg_q;
    idx_n     = idx_q + 4'd1;
    slot_n    = slot_q;
    chunk_n   = chunk_q;
    data_step = 1'b0;
    load_blk  = 1'b0;
    ctrl      = '0;
    case (seg_q)
      SEG_SIG: begin
        byte_v = psdw_pkg::sig_byte(idx_q[2:0]);
        if (idx_q == 4'd7) begin
          seg_n = SEG_LEN;
          idx_n = 4'd0;
        end
      end
      SEG_LEN: begin
        byte_v = psdw_pkg::be_byte(len_val, idx_q[1:0]);
        if (idx_q == 4'd3) begin
          seg_n = SEG_TAG;
          idx_n = 4'd0;
        end
      end
      SEG_TAG: begin
        byte_v           = psdw_pkg::be_byte(tag_val, idx_q[1:0]);
        ctrl.crc_feed    = 1'b1;
        ctrl.crc_restart = (idx_q == 4'd0);
        if (idx_q == 4'd3) begin
          idx_n = 4'd0;
          case (chunk_q)
            CH_IHDR: seg_n = SEG_IHDR;
            CH_IDAT: seg_n = SEG_ZHDR;
            default: seg_n = SEG_CRC;
          endcase
        end
      end
      SEG_IHDR: begin
        ctrl.crc_feed = 1'b1;
        case (idx_q)
          4'd0, 4'd1, 4'd2, 4'd3:
            byte_v = psdw_pkg::be_byte({17'd0, width_i}, idx_q[1:0]);
          4'd4, 4'd5, 4'd6, 4'd7:
            byte_v = psdw_pkg::be_byte({17'd0, height_i}, idx_q[1:0]);
          4'd8:    byte_v = 8'd8;   // bit depth
          4'd9:    byte_v = 8'd6;   // RGBA
          default: byte_v = 8'd0;
        endcase
        if (idx_q == 4'd12) begin
          seg_n = SEG_CRC;
          idx_n = 4'd0;
        end
      end
      SEG_ZHDR: begin
        ctrl.crc_feed = 1'b1;
        byte_v = (idx_q == 4'd0) ? 8'h78 : 8'h01;
        if (idx_q == 4'd1) begin
          seg_n = SEG_DATA;
          idx_n = 4'd0;
        end
      end
      SEG_DATA: begin
        ctrl.crc_feed = 1'b1;
        if (need_hdr) begin
          byte_v = hdr_b;
          seg_n  = SEG_BLK;
          idx_n  = 4'd1;
        end else begin
          byte_v          = samp_b;
          ctrl.adler_feed = 1'b1;
          data_step       = 1'b1;
          if (slot_q == 3'd4) begin
            if (last_q) begin
              seg_n = SEG_ADLER;
              idx_n = 4'd0;
            end else begin
              fin = 1'b1;
            end
          end else begin
            slot_n = slot_q + 3'd1;
          end
        end
      end
      SEG_BLK: begin
        ctrl.crc_feed = 1'b1;
        byte_v = hdr_b;
        if (idx_q == 4'd4) begin
          seg_n    = SEG_DATA;
          idx_n    = 4'd0;
          load_blk = 1'b1;
        end
      end
      SEG_ADLER: begin
        ctrl.crc_feed = 1'b1;
        byte_v = psdw_pkg::be_byte(adler_i, idx_q[1:0]);
        if (idx_q == 4'd3) begin
          seg_n = SEG_CRC;
          idx_n = 4'd0;
        end
      end
      SEG_CRC: begin
        byte_v = psdw_pkg::be_byte(~crc_i, idx_q[1:0]);
        if (idx_q == 4'd3) begin
          idx_n = 4'd0;
          case (chunk_q)
            CH_IHDR: fin = 1'b1;
            CH_IDAT: begin
              seg_n   = SEG_LEN;
              chunk_n = CH_IEND;
            end
            default: begin
              fin = 1'b1;
              eof = 1'b1;
            end
          endcase
        end
      end
      default: fin = 1'b1;
    endcase
    ctrl.data = byte_v;
    if (!emit) begin
      ctrl.crc_feed   = 1'b0;
      ctrl.adler_feed = 1'b0;
    end
    ctrl.adler_init = start_take;
  end

  assign ctrl_o = ctrl;

  // IDAT length: 6 + 5 * ceil(raw / 65535) + raw, from a reciprocal of 65535
  always_ff @(posedge clk_i) begin
    sum_q      <= raw_left_q + 32'(psdw_pkg::BlkMax - 1);
    nblk_q     <= 16'((33'(sum_q) + 33'(sum_q >> 16) + 33'd1) >> 16);
    idat_len_q <= raw_left_q + {14'd0, nblk_q, 2'b00} + {16'd0, nblk_q} + 32'd6;
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.out_byte    <= byte_v;
      out_q.last_of_run <= fin;
      out_q.end_of_file <= eof;
    end
    if (in_acc) begin
      pix_q <= in_if.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      out_vld_q    <= 1'b0;
      seg_q        <= SEG_SIG;
      chunk_q      <= CH_IHDR;
      phase_q      <= PH_IDLE;
      idx_q        <= 4'd0;
      slot_q       <= 3'd0;
      last_q       <= 1'b0;
      col_q        <= 14'd0;
      row_q        <= 14'd0;
      block_left_q <= 16'd0;
      raw_left_q   <= 32'd0;
    end else begin
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_q <= 1'b0;
      end
      // a beat taken on the final byte reloads the walk itself
      if (emit && !in_take) begin
        seg_q   <= seg_n;
        idx_q   <= idx_n;
        slot_q  <= slot_n;
        chunk_q <= chunk_n;
        if (fin) begin
          busy_q <= 1'b0;
        end
      end
      if (emit && !start_take) begin
        if (load_blk) begin
          block_left_q <= blk;
        end
        if (data_step) begin
          if (block_left_q != 16'd0) begin
            block_left_q <= block_left_q - 16'd1;
          end
          if (raw_left_q != 32'd0) begin
            raw_left_q <= raw_left_q - 32'd1;
          end
        end
      end
      if (start_take) begin
        busy_q       <= 1'b1;
        seg_q        <= SEG_SIG;
        idx_q        <= 4'd0;
        chunk_q      <= CH_IHDR;
        phase_q      <= PH_STREAM;
        col_q        <= 14'd0;
        row_q        <= 14'd0;
        block_left_q <= 16'd0;
        raw_left_q   <= raw_init;
      end else if (pix_take) begin
        busy_q  <= 1'b1;
        seg_q   <= (col_q == 14'd0 && row_q == 14'd0) ? SEG_LEN : SEG_DATA;
        idx_q   <= 4'd0;
        chunk_q <= CH_IDAT;
        slot_q  <= (col_q == 14'd0) ? 3'd0 : 3'd1;
        last_q  <= (col_nx >= width_i) && (row_nx >= height_i);
        if (col_nx >= width_i) begin
          col_q <= 14'd0;
          row_q <= row_nx[13:0];
          if (row_nx >= height_i) begin
            phase_q <= PH_DONE;
          end
        end else begin
          col_q <= col_nx[13:0];
        end
      end
    end
  end

  assign out_if.valid = out_vld_q;
  assign out_if.data  = out_q;
  assign streaming_o  = (phase_q == PH_STREAM);

`ifndef SYNTHESIS
  a_blk_le_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {16'd0, block_left_q} <= raw_left_q)
    else $error("stored block count exceeds bytes left");
`endif

endmodule

/* hw/rtl/png_stored_deflate_writer.sv */
// Throughput: one byte per cycle unless out_if stalls, set by the byte-wide output
// register; a start item emits 33 bytes, a pixel 4 (5 at a row start, +5 per
// stored-block header, +10 for the first pixel, +20 for the last). The next item
// enters on the last byte.
// Reset: asynchronous, active low; idle awaiting start, width and height 1.
// -----------------------------------------------------------------------------
// png_stored_deflate_writer
// Streams a PNG file (RGBA8, filter none, zlib stored blocks) from pixel beats.
// -----------------------------------------------------------------------------
module png_stored_deflate_writer (
  input  logic        clk_i,
  input  logic        rst_ni,
  psdw_in_if.sink     in_if,
  psdw_out_if.source  out_if,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i
);

  logic [14:0]        width_q, height_q;
  logic [31:0]        crc, adler;
  logic               streaming;
  psdw_pkg::ck_ctrl_t ctrl;

  // Image size registers; writes are dropped while an image is in progress
  // so its IHDR and IDAT length stay consistent.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 15'd1;
      height_q <= 15'd1;
    end else if (cfg_we_i && !streaming) begin
      case (cfg_idx_i)
        psdw_pkg::CFG_IMAGE_WIDTH:  width_q  <= psdw_pkg::clamp_side(cfg_data_i);
        psdw_pkg::CFG_IMAGE_HEIGHT: height_q <= psdw_pkg::clamp_side(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Sequencer: walks the file layout and owns the output beat register.
  psdw_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .out_if      (out_if),
    .width_i     (width_q),
    .height_i    (height_q),
    .crc_i       (crc),
    .adler_i     (adler),
    .ctrl_o      (ctrl),
    .streaming_o (streaming)
  );

  // Running CRC over each chunk and Adler over the filtered scanlines.
  psdw_checksum u_checksum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .crc_o   (crc),
    .adler_o (adler)
  );

`ifndef SYNTHESIS
  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.data.end_of_file |-> out_if.data.last_of_run)
    else $error("end of file beat not marked last of run");

  a_start_streams: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready && (in_if.data.kind == psdw_pkg::KIND_START)
    |=> streaming)
    else $error("start beat did not begin an image");

  a_cfg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && streaming |=> $stable(width_q) && $stable(height_q))
    else $error("size changed during an image");
`endif

endmodule
